// ===== rtl/current_frame_block_averager_assert.svh =====
// Assertion macros shared by the block average decimator RTL.
`ifndef CURRENT_FRAME_BLOCK_AVERAGER_ASSERT_SVH
`define CURRENT_FRAME_BLOCK_AVERAGER_ASSERT_SVH

// Checks that an expression holds at every clock edge outside reset.
`define CFBA_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("cfba assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define CFBA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfba assertion failed");

`endif

// ===== rtl/cfba_pkg.sv =====
// Types and constants of the block average decimator.
`timescale 1ns / 1ps

package cfba_pkg;

   localparam int CHANNELS  = 2;
   localparam int AVG_COUNT = 20;
   localparam int CNT_W     = $clog2(AVG_COUNT + 1);
   localparam int ACC_W     = 28;
   localparam int AVG_W     = 16;
   localparam int STAMP_W   = 32;
   localparam int QUAL_W    = 8;
   localparam int LIMIT_W   = 16;
   localparam int LEN_W     = 7;
   localparam int RAW_W     = 32;

   localparam int DIVISOR   = AVG_COUNT * 100;
   localparam int MAG_W     = ACC_W;
   localparam int DIV_L     = $clog2(DIVISOR);
   localparam int DIV_SHIFT = MAG_W + DIV_L;
   localparam int RECIP_W   = MAG_W + 2;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   localparam int QUO_W     = MAG_W + RECIP_W - DIV_SHIFT;

   localparam logic signed [RAW_W-1:0] VAL_HIGH = 32'sd3276700;
   localparam logic signed [RAW_W-1:0] VAL_LOW  = -32'sd3276500;
   localparam logic [RAW_W-1:0] RAW_ERROR  = 32'hFFFF_FFFF;
   localparam logic [RAW_W-1:0] RAW_OFFSET = 32'h8000_0000;
   localparam logic [QUAL_W-1:0] QUAL_MASK = 8'hFE;
   localparam int STATUS_ERR_BIT = 0;
   localparam logic [LEN_W-1:0] FRAME_LEN_OK = 7'd8;

   localparam logic signed [AVG_W-1:0] AVG_MAX = 16'sh7FFF;
   localparam logic signed [AVG_W-1:0] AVG_MIN = -16'sh8000;

   localparam logic [LIMIT_W-1:0] STALE_RESET = 16'd700;
   localparam logic signed [AVG_W-1:0] MARKER_RESET = -16'sh8000;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   typedef enum logic {
      OP_FRAME = 1'b0,
      OP_CHECK = 1'b1
   } op_type;

   typedef enum logic {
      CSR_STALE_LIMIT    = 1'b0,
      CSR_INVALID_MARKER = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] acc;
      logic [CNT_W-1:0]        cnt;
      logic                    good;
      logic [STAMP_W-1:0]      stamp;
      logic [QUAL_W-1:0]       qual;
   } chan_state_type;

   localparam chan_state_type STATE_RESET = '{
      acc: '0, cnt: '0, good: 1'b1, stamp: '0, qual: '0
   };

   typedef struct packed {
      logic [QUAL_W-1:0]       qual;
      logic [STAMP_W-1:0]      stamp;
      logic signed [AVG_W-1:0] current;
      logic                    fresh;
      logic                    good;
   } rsp_word_type;

endpackage

// ===== rtl/current_frame_block_averager.sv =====
// Top level of the block average decimator for current-sensor channels.
`timescale 1ns / 1ps

// The block takes one word per clock cycle while the output queue has room and returns one
// result word for each. The per-channel accumulator, sample count, good flag, timestamp and
// quality live in one state memory with a registered read; each word reads its channel as it
// is accepted, is updated in the next cycle and written back, and a following word on the same
// channel takes the updated entry by forwarding. Averages are formed in a second stage by a
// reciprocal multiply and kept in a second small memory. Results wait in a four-word output
// queue, and a word is taken only while the queue has room for every word in flight, so the
// input side never depends on the output ready in the same cycle. Entries read as their reset
// value until first written, so no clearing pass follows reset.
module current_frame_block_averager (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // now_ms[31:0], frame_length[38:32], raw_value[70:39], status_byte[78:71], zero fill
   input  logic [79:0]            req_tdata,
   // op[0], channel[1]
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // current_out[15:0], avg_timestamp[47:16], quality_code[55:48]
   output logic [55:0]            rsp_tdata,
   // valid_res[0], new_average[1]
   output logic [1:0]             rsp_tuser,
   input  logic                   csr_we,
   input  cfba_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_wdata
);

   import cfba_pkg::*;

   logic                    req_accept;
   logic [STAMP_W-1:0]      req_now;
   logic [LEN_W-1:0]        req_len;
   logic [RAW_W-1:0]        req_raw;
   logic [QUAL_W-1:0]       req_status;
   op_type                  req_op;
   logic                    req_ch;

   logic [LIMIT_W-1:0]      stale_limit_ff;
   logic signed [AVG_W-1:0] marker_ff;

   chan_state_type          state_mem [CHANNELS];
   logic [CHANNELS-1:0]     state_vld_ff;
   logic signed [AVG_W-1:0] avg_mem [CHANNELS];
   logic [CHANNELS-1:0]     avg_vld_ff;

   logic                    s1_v_ff;
   op_type                  s1_op_ff;
   logic                    s1_ch_ff;
   logic [STAMP_W-1:0]      s1_now_ff;
   logic [LEN_W-1:0]        s1_len_ff;
   logic [RAW_W-1:0]        s1_raw_ff;
   logic [QUAL_W-1:0]       s1_status_ff;
   chan_state_type          s1_state_ff;

   chan_state_type          wb_state;
   logic                    s1_fresh;
   logic                    s1_neg;
   logic [MAG_W-1:0]        s1_mag;

   logic                    s2_v_ff;
   logic                    s2_ch_ff;
   logic                    s2_fresh_ff;
   logic                    s2_good_ff;
   logic [STAMP_W-1:0]      s2_stamp_ff;
   logic [QUAL_W-1:0]       s2_qual_ff;
   logic                    s2_neg_ff;
   logic [MAG_W-1:0]        s2_mag_ff;
   logic signed [AVG_W-1:0] s2_avg_ff;

   logic [MAG_W+RECIP_W-1:0] s2_prod;
   logic [QUO_W-1:0]        s2_quo;
   logic signed [AVG_W-1:0] s2_q_sat;
   rsp_word_type            s2_word;

   rsp_word_type            fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]      fifo_wr_ptr_ff;
   logic [FIFO_AW-1:0]      fifo_rd_ptr_ff;
   logic [FIFO_AW:0]        fifo_cnt_ff;
   logic [FIFO_AW:0]        fifo_cnt_in;
   logic                    fifo_push;
   logic                    fifo_pop;
   logic [FIFO_AW+1:0]      occ;
   rsp_word_type            rsp_word;

   assign req_now    = req_tdata[31:0];
   assign req_len    = req_tdata[38:32];
   assign req_raw    = req_tdata[70:39];
   assign req_status = req_tdata[78:71];
   assign req_op     = op_type'(req_tuser[0]);
   assign req_ch     = req_tuser[1];

   assign occ = (FIFO_AW+2)'(fifo_cnt_ff) + (FIFO_AW+2)'(s1_v_ff) + (FIFO_AW+2)'(s2_v_ff);
   assign req_tready = occ < (FIFO_AW+2)'(FIFO_DEPTH);
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stale_limit_ff <= STALE_RESET;
         marker_ff      <= MARKER_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STALE_LIMIT:    stale_limit_ff <= csr_wdata;
            CSR_INVALID_MARKER: marker_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // Stage one: read the channel entry, forwarding the entry being written back.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff     <= req_op;
      s1_ch_ff     <= req_ch;
      s1_now_ff    <= req_now;
      s1_len_ff    <= req_len;
      s1_raw_ff    <= req_raw;
      s1_status_ff <= req_status;
      if (s1_v_ff && (s1_ch_ff == req_ch)) begin
         s1_state_ff <= wb_state;
      end else if (state_vld_ff[req_ch]) begin
         s1_state_ff <= state_mem[req_ch];
      end else begin
         s1_state_ff <= STATE_RESET;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         state_mem[s1_ch_ff] <= wb_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_vld_ff <= '0;
      end else if (s1_v_ff) begin
         state_vld_ff[s1_ch_ff] <= 1'b1;
      end
   end

   always_comb begin
      logic                    len_ok;
      logic                    err;
      logic signed [RAW_W-1:0] val;
      logic                    in_range;
      logic                    sample_ok;
      logic signed [ACC_W:0]   sum_wide;
      logic signed [ACC_W-1:0] sum_sat;
      logic [CNT_W-1:0]        cnt_inc;
      logic                    complete;
      logic [STAMP_W-1:0]      age;
      logic                    stale;

      len_ok    = s1_len_ff == FRAME_LEN_OK;
      err       = (s1_raw_ff == RAW_ERROR) || s1_status_ff[STATUS_ERR_BIT];
      val       = $signed(s1_raw_ff ^ RAW_OFFSET);
      in_range  = (val <= VAL_HIGH) && (val >= VAL_LOW);
      sample_ok = (s1_op_ff == OP_FRAME) && len_ok && !err && in_range;

      sum_wide = $signed({s1_state_ff.acc[ACC_W-1], s1_state_ff.acc}) + $signed(val[ACC_W:0]);
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
         sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[ACC_W-1:0];
      end

      cnt_inc  = s1_state_ff.cnt + CNT_W'(1);
      complete = cnt_inc >= CNT_W'(AVG_COUNT);
      age      = s1_now_ff - s1_state_ff.stamp;
      stale    = age > STAMP_W'(stale_limit_ff);

      wb_state = s1_state_ff;
      if (s1_op_ff == OP_FRAME) begin
         if (len_ok) begin
            wb_state.qual = s1_status_ff & QUAL_MASK;
         end
         if (sample_ok) begin
            if (complete) begin
               wb_state.acc   = '0;
               wb_state.cnt   = '0;
               wb_state.stamp = s1_now_ff;
               wb_state.good  = 1'b1;
            end else begin
               wb_state.acc = sum_sat;
               wb_state.cnt = cnt_inc;
            end
         end else begin
            wb_state.good = 1'b0;
         end
      end else if (stale) begin
         wb_state.good = 1'b0;
      end

      s1_fresh = sample_ok && complete;
      s1_neg   = sum_sat[ACC_W-1];
      s1_mag   = s1_neg ? MAG_W'(~sum_sat + 1'b1) : MAG_W'(sum_sat);
   end

   // Stage two: divide the completed sum and read the stored average.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_ch_ff    <= s1_ch_ff;
      s2_fresh_ff <= s1_fresh;
      s2_good_ff  <= wb_state.good;
      s2_stamp_ff <= wb_state.stamp;
      s2_qual_ff  <= wb_state.qual;
      s2_neg_ff   <= s1_neg;
      s2_mag_ff   <= s1_mag;
      if (s2_v_ff && s2_fresh_ff && (s2_ch_ff == s1_ch_ff)) begin
         s2_avg_ff <= s2_q_sat;
      end else if (avg_vld_ff[s1_ch_ff]) begin
         s2_avg_ff <= avg_mem[s1_ch_ff];
      end else begin
         s2_avg_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_v_ff && s2_fresh_ff) begin
         avg_mem[s2_ch_ff] <= s2_q_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_vld_ff <= '0;
      end else if (s2_v_ff && s2_fresh_ff) begin
         avg_vld_ff[s2_ch_ff] <= 1'b1;
      end
   end

   always_comb begin
      s2_prod = (MAG_W+RECIP_W)'(s2_mag_ff) * (MAG_W+RECIP_W)'(RECIP);
      s2_quo  = s2_prod[MAG_W+RECIP_W-1:DIV_SHIFT];
      if (s2_neg_ff) begin
         if (s2_quo > QUO_W'({1'b0, AVG_MIN})) begin
            s2_q_sat = AVG_MIN;
         end else begin
            s2_q_sat = $signed(AVG_W'(-s2_quo));
         end
      end else begin
         if (s2_quo > QUO_W'(AVG_MAX)) begin
            s2_q_sat = AVG_MAX;
         end else begin
            s2_q_sat = $signed(AVG_W'(s2_quo));
         end
      end

      s2_word.qual  = s2_qual_ff;
      s2_word.stamp = s2_stamp_ff;
      s2_word.fresh = s2_fresh_ff;
      s2_word.good  = s2_good_ff;
      if (!s2_good_ff) begin
         s2_word.current = marker_ff;
      end else if (s2_fresh_ff) begin
         s2_word.current = s2_q_sat;
      end else begin
         s2_word.current = s2_avg_ff;
      end
   end

   // Output queue.
   assign fifo_push  = s2_v_ff;
   assign rsp_tvalid = fifo_cnt_ff != '0;
   assign fifo_pop   = rsp_tvalid && rsp_tready;
   assign fifo_cnt_in = fifo_cnt_ff + (FIFO_AW+1)'(fifo_push) - (FIFO_AW+1)'(fifo_pop);

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_mem[fifo_wr_ptr_ff] <= s2_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_wr_ptr_ff <= '0;
         fifo_rd_ptr_ff <= '0;
         fifo_cnt_ff    <= '0;
      end else begin
         fifo_cnt_ff <= fifo_cnt_in;
         if (fifo_push) begin
            fifo_wr_ptr_ff <= fifo_wr_ptr_ff + FIFO_AW'(1);
         end
         if (fifo_pop) begin
            fifo_rd_ptr_ff <= fifo_rd_ptr_ff + FIFO_AW'(1);
         end
      end
   end

   assign rsp_word  = fifo_mem[fifo_rd_ptr_ff];
   assign rsp_tdata = {rsp_word.qual, rsp_word.stamp, rsp_word.current};
   assign rsp_tuser = {rsp_word.fresh, rsp_word.good};

`include "current_frame_block_averager_assert.svh"

   `CFBA_ASSERT_ALWAYS(a_occ_limit, clock, reset, occ <= (FIFO_AW+2)'(FIFO_DEPTH))
   `CFBA_ASSERT_IMPLY(a_push_room, clock, reset, fifo_push && !fifo_pop, !fifo_cnt_ff[FIFO_AW])
   `CFBA_ASSERT_IMPLY(a_fresh_good, clock, reset, s2_v_ff && s2_fresh_ff, s2_good_ff)

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the current-sensor block average decimator.
`timescale 1ns / 1ps

module tb_top;
   import cfba_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam logic [31:0] RAW_ZERO = 32'h8000_0000;
   localparam logic [31:0] RAW_TOP  = RAW_ZERO + 32'd3276700;
   localparam logic [31:0] RAW_BOT  = RAW_ZERO - 32'd3276500;

   typedef struct packed {
      op_type        op;
      logic          ch;
      logic [31:0]   now;
      logic [6:0]    len;
      logic [31:0]   raw;
      logic [7:0]    st;
      int            rep;
      bit            fixed;
      rsp_word_type  want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_STALE_LIMIT;
   logic [15:0] csr_wdata = '0;

   longint acc_sum [CHANNELS] = '{default: 0};
   int sample_cnt [CHANNELS] = '{default: 0};
   logic signed [15:0] avg_val [CHANNELS] = '{default: '0};
   bit chan_good [CHANNELS] = '{default: 1'b1};
   logic [31:0] avg_stamp [CHANNELS] = '{default: '0};
   logic [7:0] last_qual [CHANNELS] = '{default: '0};
   logic [15:0] stale_limit = 16'd700;
   logic signed [15:0] invalid_marker = -16'sd32768;

   rsp_word_type due_reports [$];
   int mismatches = 0;
   int cycles = 0;
   bit steady = 1'b0;
   bit hold_rsp = 1'b0;
   logic [31:0] ms_counter = '0;

   stim_row_type dir_rows [20] = '{
      '{OP_CHECK, 1'b0, 32'd0, 7'd0, 32'd0, 8'h00, 1, 1'b1,
        '{8'h00, 32'd0, 16'sh0000, 1'b0, 1'b1}},
      '{OP_CHECK, 1'b1, 32'd700, 7'd0, 32'd0, 8'h00, 1, 1'b1,
        '{8'h00, 32'd0, 16'sh0000, 1'b0, 1'b1}},
      '{OP_CHECK, 1'b1, 32'd701, 7'd0, 32'd0, 8'h00, 1, 1'b1,
        '{8'h00, 32'd0, 16'sh8000, 1'b0, 1'b0}},
      '{OP_FRAME, 1'b0, 32'd5, 7'd0, RAW_ZERO, 8'h00, 1, 1'b1,
        '{8'h00, 32'd0, 16'sh8000, 1'b0, 1'b0}},
      '{OP_FRAME, 1'b0, 32'd5, 7'd64, RAW_ZERO, 8'h00, 1, 1'b1,
        '{8'h00, 32'd0, 16'sh8000, 1'b0, 1'b0}},
      '{OP_FRAME, 1'b0, 32'd5, 7'd8, 32'hFFFF_FFFF, 8'hFF, 1, 1'b1,
        '{8'hFE, 32'd0, 16'sh8000, 1'b0, 1'b0}},
      '{OP_FRAME, 1'b0, 32'd5, 7'd8, RAW_ZERO, 8'h01, 1, 1'b1,
        '{8'h00, 32'd0, 16'sh8000, 1'b0, 1'b0}},
      '{OP_FRAME, 1'b0, 32'd5, 7'd8, RAW_TOP + 32'd1, 8'hFE, 1, 1'b1,
        '{8'hFE, 32'd0, 16'sh8000, 1'b0, 1'b0}},
      '{OP_FRAME, 1'b0, 32'd5, 7'd8, RAW_BOT - 32'd1, 8'h00, 1, 1'b1,
        '{8'h00, 32'd0, 16'sh8000, 1'b0, 1'b0}},
      '{OP_FRAME, 1'b0, 32'd5, 7'd8, 32'd0, 8'h02, 1, 1'b1,
        '{8'h02, 32'd0, 16'sh8000, 1'b0, 1'b0}},
      '{OP_FRAME, 1'b0, 32'd5, 7'd8, 32'hFFFF_FFFE, 8'h00, 1, 1'b1,
        '{8'h00, 32'd0, 16'sh8000, 1'b0, 1'b0}},
      '{OP_FRAME, 1'b1, 32'd1000, 7'd8, RAW_TOP, 8'hAA, 19, 1'b0, '0},
      '{OP_FRAME, 1'b1, 32'h1234_5678, 7'd8, RAW_TOP, 8'hAA, 1, 1'b1,
        '{8'hAA, 32'h1234_5678, 16'sh7FFF, 1'b1, 1'b1}},
      '{OP_FRAME, 1'b0, 32'hFFFF_FF00, 7'd8, RAW_BOT, 8'h54, 19, 1'b0, '0},
      '{OP_FRAME, 1'b0, 32'hFFFF_FF00, 7'd8, RAW_BOT, 8'h54, 1, 1'b1,
        '{8'h54, 32'hFFFF_FF00, 16'sh8003, 1'b1, 1'b1}},
      '{OP_CHECK, 1'b0, 32'hFFFF_FFFF, 7'd64, 32'hFFFF_FFFF, 8'hFF, 1, 1'b1,
        '{8'h54, 32'hFFFF_FF00, 16'sh8003, 1'b0, 1'b1}},
      '{OP_CHECK, 1'b0, 32'h0000_01BC, 7'd0, 32'd0, 8'h00, 1, 1'b1,
        '{8'h54, 32'hFFFF_FF00, 16'sh8003, 1'b0, 1'b1}},
      '{OP_CHECK, 1'b1, 32'h1234_5934, 7'd0, 32'd0, 8'h00, 1, 1'b1,
        '{8'hAA, 32'h1234_5678, 16'sh7FFF, 1'b0, 1'b1}},
      '{OP_CHECK, 1'b1, 32'h1234_5935, 7'd0, 32'd0, 8'h00, 1, 1'b1,
        '{8'hAA, 32'h1234_5678, 16'sh8000, 1'b0, 1'b0}},
      '{OP_FRAME, 1'b1, 32'h0000_2000, 7'd8, RAW_ZERO, 8'h00, 1, 1'b0, '0}
   };

   current_frame_block_averager u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic rsp_word_type update_channel(input op_type op, input logic ch,
                                                   input logic [31:0] now,
                                                   input logic [6:0] len,
                                                   input logic [31:0] raw,
                                                   input logic [7:0] st);
      rsp_word_type w;
      longint val;
      longint q;
      logic [31:0] age;
      w = '0;
      if (op == OP_FRAME) begin
         if (len != FRAME_LEN_OK) begin
            chan_good[ch] = 1'b0;
         end else begin
            last_qual[ch] = st & 8'hFE;
            if (raw == 32'hFFFF_FFFF || st[0]) begin
               chan_good[ch] = 1'b0;
            end else begin
               val = longint'(raw) - 64'sd2147483648;
               if (val > 64'sd3276700 || val < -64'sd3276500) begin
                  chan_good[ch] = 1'b0;
               end else begin
                  acc_sum[ch] = acc_sum[ch] + val;
                  if (acc_sum[ch] > 64'sd134217727) acc_sum[ch] = 64'sd134217727;
                  if (acc_sum[ch] < -64'sd134217728) acc_sum[ch] = -64'sd134217728;
                  sample_cnt[ch] = sample_cnt[ch] + 1;
                  if (sample_cnt[ch] >= AVG_COUNT) begin
                     q = acc_sum[ch] / longint'(AVG_COUNT * 100);
                     if (q > 64'sd32767) q = 64'sd32767;
                     if (q < -64'sd32768) q = -64'sd32768;
                     avg_val[ch] = q[15:0];
                     avg_stamp[ch] = now;
                     chan_good[ch] = 1'b1;
                     sample_cnt[ch] = 0;
                     acc_sum[ch] = 0;
                     w.fresh = 1'b1;
                  end
               end
            end
         end
      end else begin
         age = now - avg_stamp[ch];
         if (age > {16'd0, stale_limit}) chan_good[ch] = 1'b0;
      end
      w.current = chan_good[ch] ? avg_val[ch] : invalid_marker;
      w.good = chan_good[ch];
      w.stamp = avg_stamp[ch];
      w.qual = last_qual[ch];
      return w;
   endfunction

   task automatic send_word(input op_type op, input logic ch, input logic [31:0] now,
                            input logic [6:0] len, input logic [31:0] raw,
                            input logic [7:0] st, input bit fixed, input rsp_word_type want);
      int gap;
      rsp_word_type calc;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      calc = update_channel(op, ch, now, len, raw, st);
      due_reports.push_back(fixed ? want : calc);
      req_tvalid <= 1'b1;
      req_tuser <= {ch, op};
      req_tdata <= {1'b0, st, raw, len, now};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random_word;
      int kind;
      logic ch;
      logic [31:0] now;
      logic [31:0] raw;
      logic [7:0] st;
      logic [6:0] len;
      op_type op;
      kind = $urandom_range(0, 99);
      ch = 1'($urandom_range(0, 1));
      ms_counter = ms_counter + $urandom_range(0, 40);
      if ($urandom_range(0, 19) == 0) ms_counter = $urandom;
      now = ms_counter;
      op = OP_FRAME;
      len = FRAME_LEN_OK;
      st = 8'($urandom) & 8'hFE;
      raw = RAW_BOT + $urandom_range(0, 6553200);
      if ($urandom_range(0, 15) == 0) raw = $urandom_range(0, 1) ? RAW_TOP : RAW_BOT;
      if (kind >= 70 && kind < 82) begin
         op = OP_CHECK;
         if ($urandom_range(0, 3) != 0)
            now = avg_stamp[ch] + {16'd0, stale_limit} + $urandom_range(0, 2) - 32'd1;
         len = 7'($urandom_range(0, 64));
         raw = $urandom;
         st = 8'($urandom);
      end else if (kind >= 82 && kind < 86) begin
         len = 7'($urandom_range(0, 64));
      end else if (kind >= 86 && kind < 92) begin
         if ($urandom_range(0, 1)) raw = 32'hFFFF_FFFF;
         else st[0] = 1'b1;
      end else if (kind >= 92) begin
         raw = $urandom;
         st = 8'($urandom);
      end
      send_word(op, ch, now, len, raw, st, 1'b0, '0);
   endtask

   task automatic wait_reports_done;
      req_tvalid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_regs(input logic [15:0] limit, input logic [15:0] marker_val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_STALE_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_index <= CSR_INVALID_MARKER;
      csr_wdata <= marker_val;
      @(posedge clock);
      csr_we <= 1'b0;
      stale_limit = limit;
      invalid_marker = marker_val;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_word_type'({rsp_tdata, rsp_tuser});
         if (due_reports.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, got);
            mismatches++;
         end else begin
            want = due_reports.pop_front();
            check_field("current_out", 32'(want.current), 32'(got.current));
            check_field("valid_res", 32'(want.good), 32'(got.good));
            check_field("new_average", 32'(want.fresh), 32'(got.fresh));
            check_field("avg_timestamp", want.stamp, got.stamp);
            check_field("quality_code", 32'(want.qual), 32'(got.qual));
         end
      end
   end

   initial begin : rsp_side
      int d;
      forever begin
         if (hold_rsp) begin
            d = 300;
            hold_rsp = 1'b0;
         end else begin
            d = steady ? 0 : $urandom_range(0, 10);
         end
         if (d > 0) begin
            rsp_tready <= 1'b0;
            repeat (d) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : req_side
      int p;
      int i;
      int r;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (i = 0; i < 20; i++) begin
         for (r = 0; r < dir_rows[i].rep; r++) begin
            send_word(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].now, dir_rows[i].len,
                      dir_rows[i].raw, dir_rows[i].st, dir_rows[i].fixed, dir_rows[i].want);
         end
      end
      wait_reports_done;
      for (p = 0; p < 5; p++) begin
         case (p)
            0: begin
               write_regs(16'd0, 16'h7FFF);
            end
            1: begin
               write_regs(16'hFFFF, 16'h8000);
            end
            2: begin
               write_regs(16'($urandom), 16'($urandom));
            end
            3: begin
               write_regs(16'd700, 16'h0000);
            end
            default: begin
               write_regs(16'($urandom_range(0, 2000)), 16'($urandom));
            end
         endcase
         for (i = 0; i < 340; i++) begin
            steady = (p == 2 && i < 150);
            if (p == 1 && i == 40) hold_rsp = 1'b1;
            if (p == 3 && i == 170) wait_reports_done;
            send_random_word;
         end
         wait_reports_done;
      end
      steady = 1'b0;
      repeat (20) @(posedge clock);
      if (mismatches == 0 && due_reports.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cfba_pkg.sv
rtl/current_frame_block_averager.sv
tb/sv/tb_top.sv
